[sv/gesu_pkg.sv]
// Shared types, constants and arithmetic helpers for the Gaussian elimination solver.
// No dependencies.
`default_nettype none
package gesu_pkg;

  localparam int MAX_N = 8;
  localparam int ROW_W = 3;
  localparam int COL_W = 4;
  localparam int ADDR_W = 7;
  localparam int CELLS = MAX_N * (MAX_N + 1);
  localparam logic [COL_W-1:0] RHS_COL = 4'd8;

  localparam logic [1:0] CFG_SIZE = 2'd0;
  localparam logic [1:0] CFG_THR = 2'd1;

  typedef struct packed {
    logic              valid;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [31:0]       value;
    logic              last;
  } ld_t;

  typedef struct packed {
    logic [3:0]  size;
    logic [15:0] thr;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] idx;
    logic [31:0]      value;
    logic             last;
  } res_t;

  // row-major cells, nine per row, column 8 holds the right-hand side
  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    addr_of = {1'b0, r, 3'b000} + {4'b0000, r} + {3'b000, c};
  endfunction

  function automatic logic [32:0] mag(input logic [31:0] v);
    mag = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) sat_sub = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else sat_sub = d[31:0];
  endfunction

endpackage
`default_nettype wire

[sv/gesu_div.sv]
// Iterative Q16.16 divider, one quotient bit per cycle, saturating.
// Depends on nothing.
`default_nettype none
module gesu_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done_r,
  output logic [31:0]      q_r
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_SAT} dstate_t;

  dstate_t     state_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [47:0] num_r;
  logic [31:0] den_r;
  logic        neg_r;
  logic [32:0] rem_sh;
  logic        fits;
  logic [31:0] a_mag;
  logic [31:0] b_mag;

  assign a_mag = dividend[31] ? (32'd0 - dividend) : dividend;
  assign b_mag = divisor[31] ? (32'd0 - divisor) : divisor;
  assign rem_sh = {rem_r, num_r[47]};
  assign fits = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            if (divisor == 32'd0) begin
              q_r <= (dividend == 32'd0) ? 32'd0 :
                     (dividend[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
              done_r <= 1'b1;
            end else begin
              num_r <= {a_mag, 16'h0000};
              den_r <= b_mag;
              rem_r <= '0;
              neg_r <= dividend[31] ^ divisor[31];
              cnt_r <= 6'd47;
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_r <= fits ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
          num_r <= {num_r[46:0], fits};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) state_r <= D_SAT;
        end
        D_SAT: begin
          if (!neg_r) q_r <= (num_r > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_r[31:0];
          else q_r <= (num_r > 48'h8000_0000) ? 32'h8000_0000 : (32'd0 - num_r[31:0]);
          done_r <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/gesu_core.sv]
// Element stores, working matrix and the elimination / back-substitution sequencer.
// Depends on gesu_pkg and gesu_div.
`default_nettype none
module gesu_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gesu_pkg::ld_t   ld,
  input  wire gesu_pkg::cfg_t  cfg,
  output logic                 idle,
  output logic                 res_valid,
  output gesu_pkg::res_t       res,
  input  wire logic            res_ready
);

  typedef enum logic [4:0] {
    S_IDLE, S_COPY, S_PV_RD, S_PV_CMP, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
    S_NM_RD, S_NM_PIV, S_EL_RD, S_EL_DIV, S_EL_WAIT, S_EL_KRD, S_EL_SUB,
    S_BS_RD, S_BS_EMIT, S_BS_ARD, S_BS_MUL, S_BS_SCL, S_BS_YRD, S_BS_SUB
  } state_t;

  localparam int AW = gesu_pkg::ADDR_W;

  logic [31:0] smem [gesu_pkg::CELLS];
  logic [31:0] wmem [gesu_pkg::CELLS];
  logic [31:0] srd_r;
  logic [31:0] wrd_r;

  state_t      state_r;
  logic [2:0]  k_r, i_r, sel_r;
  logic [3:0]  j_r;
  logic [3:0]  n_r;
  logic [6:0]  cnt_r;
  logic [32:0] best_r;
  logic [31:0] piv_r, tmp_r, xk_r, mq_r;
  logic [15:0] thr_r;
  logic signed [63:0] prod_r;

  logic [2:0]  nm1;
  logic [3:0]  j_next;
  logic        j_end;
  logic        take;
  logic        s_wen, s_ren, w_wen, w_ren;
  logic [AW-1:0] s_waddr, s_raddr, w_waddr, w_raddr;
  logic [31:0] w_wdata;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic [63:0] prod_adj;
  logic [47:0] prod_sh;
  logic [31:0] mq_nxt;
  logic [3:0]  n_nxt;

  assign nm1 = 3'(n_r - 4'd1);
  assign j_end = (j_r == gesu_pkg::RHS_COL);
  assign j_next = (j_r[2:0] == nm1) ? gesu_pkg::RHS_COL : j_r + 4'd1;
  assign take = (i_r == k_r) || (gesu_pkg::mag(wrd_r) > best_r);
  assign n_nxt = (cfg.size == 4'd0) ? 4'd1 :
                 (cfg.size > 4'(gesu_pkg::MAX_N)) ? 4'(gesu_pkg::MAX_N) : cfg.size;

  // truncate toward zero when scaling the product back to Q16.16
  assign prod_adj = prod_r + (prod_r[63] ? 64'd65535 : 64'd0);
  assign prod_sh = prod_adj[63:16];
  assign mq_nxt = ($signed(prod_sh) > 48'sh7FFF_FFFF) ? 32'h7FFF_FFFF :
                  ($signed(prod_sh) < -48'sh8000_0000) ? 32'h8000_0000 : prod_sh[31:0];

  assign idle = (state_r == S_IDLE);
  assign res_valid = (state_r == S_BS_EMIT);
  assign res.idx = k_r;
  assign res.value = wrd_r;
  assign res.last = (k_r == 3'd0);

  gesu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wrd_r),
    .divisor  (piv_r),
    .done_r   (div_done),
    .q_r      (div_q)
  );

  always_comb begin
    s_wen = ld.valid && (ld.col <= gesu_pkg::RHS_COL);
    s_waddr = gesu_pkg::addr_of(ld.row, ld.col);
    s_ren = (state_r == S_COPY) && (cnt_r < 7'(gesu_pkg::CELLS));
    s_raddr = cnt_r;
    w_ren = 1'b0;
    w_raddr = '0;
    w_wen = 1'b0;
    w_waddr = '0;
    w_wdata = wrd_r;
    div_start = 1'b0;
    case (state_r)
      S_COPY: begin
        w_wen = (cnt_r != 7'd0);
        w_waddr = cnt_r - 7'd1;
        w_wdata = srd_r;
      end
      S_PV_RD, S_NM_RD: begin
        w_ren = 1'b1;
        w_raddr = gesu_pkg::addr_of(i_r, {1'b0, k_r});
      end
      S_SW_RA, S_EL_KRD: begin
        w_ren = 1'b1;
        w_raddr = gesu_pkg::addr_of(k_r, j_r);
      end
      S_SW_RB: begin
        w_ren = 1'b1;
        w_raddr = gesu_pkg::addr_of(sel_r, j_r);
      end
      S_SW_WA: begin
        w_wen = 1'b1;
        w_waddr = gesu_pkg::addr_of(k_r, j_r);
      end
      S_SW_WB: begin
        w_wen = 1'b1;
        w_waddr = gesu_pkg::addr_of(sel_r, j_r);
        w_wdata = tmp_r;
      end
      S_EL_RD: begin
        w_ren = 1'b1;
        w_raddr = gesu_pkg::addr_of(i_r, j_r);
      end
      S_EL_DIV: div_start = 1'b1;
      S_EL_WAIT: begin
        w_wen = div_done && (i_r == k_r);
        w_waddr = gesu_pkg::addr_of(i_r, j_r);
        w_wdata = div_q;
      end
      S_EL_SUB: begin
        w_wen = 1'b1;
        w_waddr = gesu_pkg::addr_of(i_r, j_r);
        w_wdata = gesu_pkg::sat_sub(tmp_r, wrd_r);
      end
      S_BS_RD: begin
        w_ren = 1'b1;
        w_raddr = gesu_pkg::addr_of(k_r, gesu_pkg::RHS_COL);
      end
      S_BS_ARD: begin
        w_ren = 1'b1;
        w_raddr = gesu_pkg::addr_of(i_r, {1'b0, k_r});
      end
      S_BS_YRD: begin
        w_ren = 1'b1;
        w_raddr = gesu_pkg::addr_of(i_r, gesu_pkg::RHS_COL);
      end
      S_BS_SUB: begin
        w_wen = 1'b1;
        w_waddr = gesu_pkg::addr_of(i_r, gesu_pkg::RHS_COL);
        w_wdata = gesu_pkg::sat_sub(wrd_r, mq_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_wen) smem[s_waddr] <= ld.value;
    if (s_ren) srd_r <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (w_wen) wmem[w_waddr] <= w_wdata;
    if (w_ren) wrd_r <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r <= '0;
      i_r <= '0;
      j_r <= '0;
      sel_r <= '0;
      cnt_r <= '0;
      n_r <= 4'd1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (ld.valid && ld.last) begin
            n_r <= n_nxt;
            thr_r <= cfg.thr;
            cnt_r <= '0;
            state_r <= S_COPY;
          end
        end
        S_COPY: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(gesu_pkg::CELLS)) begin
            k_r <= '0;
            i_r <= '0;
            state_r <= S_PV_RD;
          end
        end
        S_PV_RD: state_r <= S_PV_CMP;
        S_PV_CMP: begin
          if (take) begin
            best_r <= gesu_pkg::mag(wrd_r);
            sel_r <= i_r;
          end
          if (i_r == nm1) begin
            j_r <= '0;
            i_r <= k_r;
            if ((take ? i_r : sel_r) != k_r) state_r <= S_SW_RA;
            else state_r <= S_NM_RD;
          end else begin
            i_r <= i_r + 3'd1;
            state_r <= S_PV_RD;
          end
        end
        S_SW_RA: state_r <= S_SW_RB;
        S_SW_RB: begin
          tmp_r <= wrd_r;
          state_r <= S_SW_WA;
        end
        S_SW_WA: state_r <= S_SW_WB;
        S_SW_WB: begin
          if (j_end) state_r <= S_NM_RD;
          else begin
            j_r <= j_next;
            state_r <= S_SW_RA;
          end
        end
        S_NM_RD: state_r <= S_NM_PIV;
        S_NM_PIV: begin
          piv_r <= wrd_r;
          j_r <= '0;
          if (gesu_pkg::mag(wrd_r) < {17'd0, thr_r}) begin
            if (i_r != nm1) begin
              i_r <= i_r + 3'd1;
              state_r <= S_NM_RD;
            end else if (k_r == nm1) state_r <= S_BS_RD;
            else begin
              k_r <= k_r + 3'd1;
              i_r <= k_r + 3'd1;
              state_r <= S_PV_RD;
            end
          end else state_r <= S_EL_RD;
        end
        S_EL_RD: state_r <= S_EL_DIV;
        S_EL_DIV: state_r <= S_EL_WAIT;
        S_EL_WAIT, S_EL_SUB: begin
          if (state_r == S_EL_WAIT) tmp_r <= div_q;
          if (state_r == S_EL_WAIT && !div_done) state_r <= S_EL_WAIT;
          else if (state_r == S_EL_WAIT && i_r != k_r) state_r <= S_EL_KRD;
          else if (!j_end) begin
            j_r <= j_next;
            state_r <= S_EL_RD;
          end else if (i_r != nm1) begin
            i_r <= i_r + 3'd1;
            state_r <= S_NM_RD;
          end else if (k_r == nm1) state_r <= S_BS_RD;
          else begin
            k_r <= k_r + 3'd1;
            i_r <= k_r + 3'd1;
            state_r <= S_PV_RD;
          end
        end
        S_EL_KRD: state_r <= S_EL_SUB;
        S_BS_RD: state_r <= S_BS_EMIT;
        S_BS_EMIT: begin
          if (res_ready) begin
            xk_r <= wrd_r;
            i_r <= '0;
            if (k_r == 3'd0) state_r <= S_IDLE;
            else state_r <= S_BS_ARD;
          end
        end
        S_BS_ARD: state_r <= S_BS_MUL;
        S_BS_MUL: begin
          prod_r <= $signed(wrd_r) * $signed(xk_r);
          state_r <= S_BS_SCL;
        end
        S_BS_SCL: begin
          mq_r <= mq_nxt;
          state_r <= S_BS_YRD;
        end
        S_BS_YRD: state_r <= S_BS_SUB;
        S_BS_SUB: begin
          if (i_r == k_r - 3'd1) begin
            k_r <= k_r - 3'd1;
            state_r <= S_BS_RD;
          end else begin
            i_r <= i_r + 3'd1;
            state_r <= S_BS_ARD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/gauss_elimination_solver_unit.sv]
// Top level: configuration registers, request intake and result output register.
// Depends on gesu_pkg and gesu_core.
//
//  channel | direction | payload                                          | handshake
//  in_     | input     | row_index, column_index, element_value, last_elt | in_valid/in_ready
//  out_    | output    | solution_index, solution_value, last_solution    | out_valid/out_ready
//  cfg_    | input     | cfg_index (0 size, 1 threshold), cfg_data        | cfg_valid/cfg_ready
//
// A load request without the last mark leaves the intake open. A last request copies the
// 72-cell store to the working matrix, then eliminates: every cell update runs through
// the shared 48-step divider, on the pivot row and on the rows below it, and back
// substitution by multiply-subtract follows. Rows under the threshold skip the divider.
// in_ready is low for the whole solve. Results wait in one output register; a stalled
// out_ready holds the sequencer. Synchronous active-low reset clears control and sets
// the configuration to size 8 and threshold 1.
`default_nettype none
module gauss_elimination_solver_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_row_index,
  input  wire logic [3:0]  in_column_index,
  input  wire logic [31:0] in_element_value,
  input  wire logic        in_last_element,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_solution_index,
  output logic [31:0]      out_solution_value,
  output logic             out_last_solution,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  gesu_pkg::cfg_t cfg_r;
  gesu_pkg::ld_t  ld;
  gesu_pkg::res_t res;
  gesu_pkg::res_t out_r;
  logic           out_valid_r;
  logic           core_idle;
  logic           res_valid;
  logic           res_ready;

  assign in_ready = core_idle;
  assign cfg_ready = 1'b1;
  assign ld.valid = in_valid && core_idle;
  assign ld.row = in_row_index;
  assign ld.col = in_column_index;
  assign ld.value = in_element_value;
  assign ld.last = in_last_element;
  assign res_ready = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_solution_index = out_r.idx;
  assign out_solution_value = out_r.value;
  assign out_last_solution = out_r.last;

  gesu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .cfg       (cfg_r),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size <= 4'd8;
      cfg_r.thr <= 16'd1;
    end else if (cfg_valid) begin
      if (cfg_index == gesu_pkg::CFG_SIZE) cfg_r.size <= cfg_data[3:0];
      else if (cfg_index == gesu_pkg::CFG_THR) cfg_r.thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_ready) out_valid_r <= res_valid;
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

endmodule
`default_nettype wire

[sv/gesu_checker.sv]
// Port-level checks for the solver top level, with the bind that attaches them.
// Depends on gauss_elimination_solver_unit.
`default_nettype none
module gesu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last_element,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_solution_index,
  input wire logic [31:0] out_solution_value,
  input wire logic        out_last_solution
);

  a_solve_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_element) |=> !in_ready)
    else $error("intake open right after a solve request");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_last_element) |=> in_ready)
    else $error("plain load request left intake closed");

  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_solution) |-> (out_solution_index == 3'd0))
    else $error("last solution not for unknown zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_solution_value)))
    else $error("stalled result changed");

endmodule

bind gauss_elimination_solver_unit gesu_checker u_gesu_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_last_element    (in_last_element),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_solution_index (out_solution_index),
  .out_solution_value (out_solution_value),
  .out_last_solution  (out_last_solution)
);
`default_nettype wire
